// ----- rtl/mce_pkg.sv -----
// ----------------------------------------------------------------------------
// mce_pkg
// Shared codes and fixed widths of the modular exponentiation character cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package mce_pkg;

  // opcode values
  localparam logic OPC_ENCRYPT = 1'b0;
  localparam logic OPC_DECRYPT = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd2;

  // payload widths
  localparam int unsigned DIN_W  = 25;
  localparam int unsigned DOUT_W = 26;
  // magnitude of the base: |data_in - 97| fits in 25 bits
  localparam int unsigned MAG_W  = 25;

  // offset between character code and exponentiation base
  localparam int unsigned CHAR_OFFSET = 97;

  // reset value of the modulus
  localparam int unsigned MODULUS_RST = 2;

endpackage

`default_nettype wire

// ----- rtl/modexp_char_cipher.sv -----
// ----------------------------------------------------------------------------
// modexp_char_cipher
// Modular exponentiation of one character or ciphertext value per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries opcode_i and data_in_i.
//   Encrypt raises (data_in - 97) to the public exponent, decrypt raises
//   data_in to the private exponent and adds 97; the power is reduced mod the
//   modulus with the sign of base^exp kept on the reduced magnitude.
//   Output channel (out_valid_o / out_stall_i) carries data_out_o.
//   Configuration writes (cfg_valid_i / cfg_ready_o, index 0 modulus,
//   1 public exponent, 2 private exponent) are taken at any time, ready is
//   always high; write them only while no beat is in flight.
//   A modular multiply runs DW bit steps on the single bit-serial multiplier
//   (DW is the larger of MOD_WIDTH and 25), framed by a registered start and
//   a registered done. An item needs one reduction plus at most
//   2 * MOD_WIDTH - 1 multiplies before the sequencer reaches its done state
//   and registers the result; a zero exponent or zero modulus skips the
//   multiplier and goes straight to the done state. One item is in work at a
//   time; the next input beat is taken the cycle after the result is
//   registered. A stalled result holds the output register, the next item
//   still runs and then waits with in_stall_o high. Reset empties the output
//   register, returns the sequencer to idle and loads modulus 2 and zero
//   exponents.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_char_cipher #(
  parameter int unsigned MOD_WIDTH = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mce_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [MOD_WIDTH-1:0]              cfg_data_i,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              opcode_i,
  input  wire logic signed [mce_pkg::DIN_W-1:0]  data_in_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [mce_pkg::DOUT_W-1:0]      data_out_o
);

  localparam int unsigned DW = (MOD_WIDTH > mce_pkg::MAG_W) ? MOD_WIDTH : mce_pkg::MAG_W;
  localparam int unsigned BW = mce_pkg::DOUT_W;
  localparam int unsigned SW = (MOD_WIDTH + 2 > mce_pkg::DOUT_W) ? MOD_WIDTH + 2
                                                                : mce_pkg::DOUT_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RED   = 3'd1;
  localparam logic [2:0] ST_MUL_A = 3'd2;
  localparam logic [2:0] ST_MUL_S = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [MOD_WIDTH-1:0] modulus_q, pub_exp_q, priv_exp_q;

  logic [2:0]               state_q, state_d;
  logic                     start_q, start_d;
  logic [MOD_WIDTH-1:0]     e_q, e_d;
  logic                     op_q, op_d;
  logic                     neg_q, neg_d;
  logic                     odd_q, odd_d;
  logic [mce_pkg::MAG_W-1:0] mag_q, mag_d;
  logic [MOD_WIDTH-1:0]     acc_q, acc_d;
  logic [MOD_WIDTH-1:0]     sq_q, sq_d;
  logic                     out_valid_q, out_valid_d;
  logic [mce_pkg::DOUT_W-1:0] out_q, out_d;

  logic                 in_accept;
  logic                 out_accept;
  logic [BW-1:0]        din_x;
  logic [BW-1:0]        base;
  logic [BW-1:0]        base_abs;
  logic [MOD_WIDTH-1:0] exp_sel;
  logic [MOD_WIDTH-1:0] acc_init;
  logic                 mul_done;
  logic [MOD_WIDTH-1:0] mul_res;
  logic [MOD_WIDTH-1:0] mul_a;
  logic [DW-1:0]        mul_b;
  logic                 res_neg;
  logic [SW-1:0]        offset;
  logic [SW-1:0]        acc_x;
  logic [SW-1:0]        res_sum;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MOD_WIDTH'(mce_pkg::MODULUS_RST);
      pub_exp_q  <= '0;
      priv_exp_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mce_pkg::CFG_MODULUS:     modulus_q  <= cfg_data_i;
        mce_pkg::CFG_PUBLIC_EXP:  pub_exp_q  <= cfg_data_i;
        mce_pkg::CFG_PRIVATE_EXP: priv_exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // base and its magnitude from the input beat
  always_comb begin
    din_x = {data_in_i[mce_pkg::DIN_W-1], data_in_i};
    if (opcode_i == mce_pkg::OPC_ENCRYPT) begin
      base    = din_x - BW'(mce_pkg::CHAR_OFFSET);
      exp_sel = pub_exp_q;
    end else begin
      base    = din_x;
      exp_sel = priv_exp_q;
    end
    base_abs = base[BW-1] ? (~base + 1'b1) : base;
    acc_init = (modulus_q == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
  end

  // multiplier operands follow the current state
  always_comb begin
    case (state_q)
      ST_RED: begin
        mul_a = acc_init;
        mul_b = DW'(mag_q);
      end
      ST_MUL_A: begin
        mul_a = acc_q;
        mul_b = DW'(sq_q);
      end
      default: begin
        mul_a = sq_q;
        mul_b = DW'(sq_q);
      end
    endcase
  end

  mce_modmul #(
    .MOD_WIDTH (MOD_WIDTH),
    .DW        (DW)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .n_i     (modulus_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // signed result with the character offset
  always_comb begin
    res_neg = neg_q && odd_q && (acc_q != '0);
    offset  = (op_q == mce_pkg::OPC_DECRYPT) ? SW'(mce_pkg::CHAR_OFFSET) : '0;
    acc_x   = SW'(acc_q);
    res_sum = res_neg ? (offset - acc_x) : (offset + acc_x);
  end

  // square-and-multiply sequencer, exponent bits taken lsb first
  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    e_d         = e_q;
    op_d        = op_q;
    neg_d       = neg_q;
    odd_d       = odd_q;
    mag_d       = mag_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    out_valid_d = out_valid_q && !out_accept;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d  = opcode_i;
          neg_d = base[BW-1];
          odd_d = exp_sel[0];
          e_d   = exp_sel;
          mag_d = base_abs[mce_pkg::MAG_W-1:0];
          if (exp_sel == '0) begin
            acc_d   = MOD_WIDTH'(1);
            state_d = ST_DONE;
          end else if (modulus_q == '0) begin
            acc_d   = '0;
            state_d = ST_DONE;
          end else begin
            acc_d   = acc_init;
            start_d = 1'b1;
            state_d = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mul_done) begin
          sq_d    = mul_res;
          start_d = 1'b1;
          state_d = e_q[0] ? ST_MUL_A : ST_MUL_S;
        end
      end
      ST_MUL_A: begin
        if (mul_done) begin
          acc_d = mul_res;
          if (e_q[MOD_WIDTH-1:1] == '0) begin
            state_d = ST_DONE;
          end else begin
            start_d = 1'b1;
            state_d = ST_MUL_S;
          end
        end
      end
      ST_MUL_S: begin
        if (mul_done) begin
          sq_d    = mul_res;
          e_d     = {1'b0, e_q[MOD_WIDTH-1:1]};
          start_d = 1'b1;
          state_d = e_q[1] ? ST_MUL_A : ST_MUL_S;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_sum[mce_pkg::DOUT_W-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    op_q  <= op_d;
    neg_q <= neg_d;
    odd_q <= odd_d;
    mag_q <= mag_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_q;

  // an accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("accepted beat left sequencer idle");

  // the multiplier only finishes while the sequencer waits on it
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_RED || state_q == ST_MUL_A || state_q == ST_MUL_S))
    else $error("multiplier done outside a multiply state");

  // every product is reduced below the modulus
  a_res_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (mul_res < modulus_q))
    else $error("multiplier result not reduced");

  // exponent bits remain while multiplies are pending
  a_exp_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_A || state_q == ST_MUL_S) |-> (e_q != '0))
    else $error("multiply with exhausted exponent");

endmodule

`default_nettype wire

// ----- rtl/mce_modmul.sv -----
// ----------------------------------------------------------------------------
// mce_modmul
// Bit-serial interleaved modular multiplier: res = a * b mod n, one bit of b
// per cycle, most significant bit first. Requires a < n.
// ----------------------------------------------------------------------------
`default_nettype none

module mce_modmul #(
  parameter int unsigned MOD_WIDTH = 24,
  parameter int unsigned DW        = 25
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [MOD_WIDTH-1:0] a_i,
  input  wire logic [DW-1:0]        b_i,
  input  wire logic [MOD_WIDTH-1:0] n_i,
  output logic                      done_o,
  output logic [MOD_WIDTH-1:0]      res_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);
  localparam int unsigned ACC_W = MOD_WIDTH + 2;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [MOD_WIDTH-1:0] a_q, a_d;
  logic [DW-1:0]        b_q, b_d;
  logic [MOD_WIDTH-1:0] r_q, r_d;

  logic [ACC_W-1:0] dbl;
  logic [ACC_W-1:0] n1;
  logic [ACC_W-1:0] n2;
  logic [ACC_W-1:0] red;

  // one step: r = 2r + bit*a, then subtract n or 2n (value stays below 3n)
  always_comb begin
    n1  = {2'b00, n_i};
    n2  = {1'b0, n_i, 1'b0};
    dbl = {1'b0, r_q, 1'b0} + (b_q[DW-1] ? {2'b00, a_q} : '0);
    if (dbl >= n2) begin
      red = dbl - n2;
    end else if (dbl >= n1) begin
      red = dbl - n1;
    end else begin
      red = dbl;
    end
  end

  // sequencing of the bit loop
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DW[CNT_W-1:0];
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d   = red[MOD_WIDTH-1:0];
      b_d   = {b_q[DW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

  // partial remainder stays reduced while the loop runs
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (r_q < n_i))
    else $error("modmul remainder not reduced");

  // a new operation is never started on top of a running one
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("modmul started while busy");

  // done comes exactly when the last bit step finishes
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && (cnt_q == '0)))
    else $error("modmul done without finishing the bit loop");

endmodule

`default_nettype wire
